@@ sv/acfe_pkg.sv @@
// Package for the air-conditioner IR frame encoder.
// Holds shared types, timing constants and the bit-reverse helper; no dependencies.
package acfe_pkg;

  localparam int unsigned NumBytes = 12;
  localparam int unsigned DurW     = 13;
  localparam int unsigned IdxW     = 7;

  typedef logic [NumBytes-1:0][7:0] frame_t;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_NEXT  = 1'b1
  } req_e;

  typedef enum logic {
    PROTO_SIX    = 1'b0,
    PROTO_TWELVE = 1'b1
  } proto_e;

  localparam logic [2:0] MODE_AUTO = 3'd0;
  localparam logic [2:0] MODE_COOL = 3'd1;
  localparam logic [2:0] MODE_DRY  = 3'd2;
  localparam logic [2:0] MODE_FAN  = 3'd3;
  localparam logic [2:0] MODE_HEAT = 3'd4;

  localparam logic [7:0] P0_ID_BYTE   = 8'hA1;
  localparam logic [7:0] P1_BASE_BYTE = 8'h18;
  localparam logic [7:0] P1_ID_BYTE   = 8'hA5;

  // Six-byte protocol timing
  localparam logic [DurW-1:0] P0_HDR_US  = 13'd4480;
  localparam logic [DurW-1:0] P0_MARK_US = 13'd560;
  localparam logic [DurW-1:0] P0_ZERO_US = 13'd560;
  localparam logic [DurW-1:0] P0_ONE_US  = 13'd1680;
  localparam logic [DurW-1:0] P0_GAP_US  = 13'd5600;
  localparam logic [IdxW-1:0] P0_HALF    = 7'd50;
  localparam logic [IdxW-1:0] P0_FOOT    = 7'd49;

  // Twelve-byte protocol timing
  localparam logic [DurW-1:0] P1_HDR_MARK_US  = 13'd6130;
  localparam logic [DurW-1:0] P1_HDR_SPACE_US = 13'd7360;
  localparam logic [DurW-1:0] P1_MARK_US      = 13'd550;
  localparam logic [DurW-1:0] P1_ZERO_US      = 13'd560;
  localparam logic [DurW-1:0] P1_ONE_US       = 13'd1650;
  localparam logic [DurW-1:0] P1_FOOT_MARK_US = 13'd545;
  localparam logic [DurW-1:0] P1_FOOT_US      = 13'd7380;
  localparam logic [IdxW-1:0] P1_LAST_BIT     = 7'd96;
  localparam logic [IdxW-1:0] P1_FOOT         = 7'd97;

  typedef struct packed {
    logic [DurW-1:0] mark;
    logic [DurW-1:0] space;
    logic            last;
  } pair_t;

  function automatic logic [7:0] rev8(input logic [7:0] x);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = x[7-i];
    end
    return r;
  endfunction

endpackage

@@ sv/acfe_frame_build.sv @@
// Builds the frame bytes for either protocol from one set of settings.
// Depends on acfe_pkg.
module acfe_frame_build (
  input  logic            proto_i,
  input  logic            power_on_i,
  input  logic [2:0]      mode_i,
  input  logic [1:0]      fan_speed_i,
  input  logic [7:0]      temperature_c_i,
  input  logic            turbo_i,
  output acfe_pkg::frame_t frame_o
);
  import acfe_pkg::*;

  logic [2:0] code6;
  logic [2:0] code12;
  logic [7:0] t6;
  logic [7:0] t12;
  logic [7:0] b4_6;
  logic [7:0] b3_6;
  logic [7:0] sum6;
  logic [7:0] fmask;
  logic [7:0] b3_12;
  logic [7:0] b5_12;
  logic [7:0] b7_12;
  logic [7:0] b9_12;

  always_comb begin
    unique case (mode_i)
      MODE_AUTO: code6 = 3'd2;
      MODE_COOL: code6 = 3'd0;
      MODE_DRY:  code6 = 3'd1;
      MODE_FAN:  code6 = 3'd4;
      MODE_HEAT: code6 = 3'd3;
      default:   code6 = 3'd2;
    endcase
    code12 = (mode_i > MODE_HEAT) ? MODE_AUTO : mode_i;

    unique case (fan_speed_i)
      2'd1:    fmask = 8'h60;
      2'd2:    fmask = 8'h40;
      2'd3:    fmask = 8'h20;
      default: fmask = 8'h00;
    endcase
  end

  assign t6  = (temperature_c_i < 8'd17) ? 8'd17 :
               (temperature_c_i > 8'd30) ? 8'd30 : temperature_c_i;
  assign t12 = (temperature_c_i < 8'd16) ? 8'd16 :
               (temperature_c_i > 8'd31) ? 8'd31 : temperature_c_i;

  assign b4_6 = {power_on_i, 2'b00, fan_speed_i, code6};
  assign b3_6 = t6 - 8'd17;
  // bytes 5, 2 and 1 contribute a fixed 0x83 to the reversed sum
  assign sum6 = 8'h83 + rev8(b4_6) + rev8(b3_6);

  assign b3_12 = turbo_i ? 8'h08 : 8'h00;
  assign b5_12 = turbo_i ? 8'h0A : 8'h00;
  assign b7_12 = P1_BASE_BYTE | {6'd0, power_on_i, 1'b0} | fmask;
  assign b9_12 = {code12, 1'b0, 4'(t12 - 8'd16)};

  always_comb begin
    frame_o = '0;
    if (proto_i == PROTO_TWELVE) begin
      frame_o[3]  = b3_12;
      frame_o[5]  = b5_12;
      frame_o[7]  = b7_12;
      frame_o[9]  = b9_12;
      frame_o[10] = P1_ID_BYTE;
      frame_o[11] = b3_12 + b5_12 + b7_12 + b9_12 + P1_ID_BYTE;
    end else begin
      frame_o[5] = P0_ID_BYTE;
      frame_o[4] = b4_6;
      frame_o[3] = b3_6;
      frame_o[2] = 8'hFF;
      frame_o[1] = 8'hFF;
      frame_o[0] = rev8(8'h00 - sum6);
    end
  end

endmodule

@@ sv/acfe_pair_gen.sv @@
// Maps a pair index of the stored frame to a mark/space pair.
// Depends on acfe_pkg.
module acfe_pair_gen (
  input  logic                        proto_i,
  input  logic [acfe_pkg::IdxW-1:0]   idx_i,
  input  acfe_pkg::frame_t            frame_i,
  output acfe_pkg::pair_t             pair_o
);
  import acfe_pkg::*;

  logic            inv;
  logic [IdxW-1:0] q;
  logic [IdxW-1:0] k6;
  logic [IdxW-1:0] k12;
  logic [3:0]      sel6;
  logic [3:0]      sel12;
  logic [7:0]      byte6;
  logic [7:0]      byte12;
  logic            bit6;
  logic            bit12;

  assign inv   = (idx_i >= P0_HALF);
  assign q     = inv ? (idx_i - P0_HALF) : idx_i;
  assign k6    = q - 7'd1;
  assign k12   = idx_i - 7'd1;
  assign sel6  = 4'd5 - {1'b0, k6[5:3]};
  assign sel12 = k12[6:3];
  assign byte6  = (sel6 < 4'(NumBytes)) ? frame_i[sel6] : 8'h00;
  assign byte12 = (sel12 < 4'(NumBytes)) ? frame_i[sel12] : 8'h00;
  assign bit6  = byte6[3'd7 - k6[2:0]] ^ inv;
  assign bit12 = byte12[k12[2:0]];

  always_comb begin
    pair_o = '0;
    if (proto_i == PROTO_SIX) begin
      if (q == '0) begin
        pair_o.mark  = P0_HDR_US;
        pair_o.space = P0_HDR_US;
      end else if (q >= P0_FOOT) begin
        pair_o.mark  = P0_MARK_US;
        pair_o.space = inv ? '0 : P0_GAP_US;
        pair_o.last  = inv;
      end else begin
        pair_o.mark  = P0_MARK_US;
        pair_o.space = bit6 ? P0_ONE_US : P0_ZERO_US;
      end
    end else begin
      if (idx_i == '0) begin
        pair_o.mark  = P1_HDR_MARK_US;
        pair_o.space = P1_HDR_SPACE_US;
      end else if (idx_i <= P1_LAST_BIT) begin
        pair_o.mark  = P1_MARK_US;
        pair_o.space = bit12 ? P1_ONE_US : P1_ZERO_US;
      end else if (idx_i == P1_FOOT) begin
        pair_o.mark  = P1_FOOT_MARK_US;
        pair_o.space = P1_FOOT_US;
      end else begin
        pair_o.mark  = P1_FOOT_MARK_US;
        pair_o.last  = 1'b1;
      end
    end
  end

endmodule

@@ sv/ac_ir_remote_frame_encoder_core.sv @@
// Top level of the IR frame encoder: input register, frame state, result register.
// Depends on acfe_pkg, acfe_frame_build and acfe_pair_gen.
// Path: the input register takes the transfer, then the result register loads from it
// once the output can accept; the frame and pair logic between them is combinational.
// Throughput: one request per cycle while the output is not stalled.
// Reset: async active low; clears valids, frame state and the protocol register.
// Frame bytes are not reset; they are only read after a start request fills them.
module ac_ir_remote_frame_encoder_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic                        power_on_i,
  input  logic [2:0]                  mode_i,
  input  logic [1:0]                  fan_speed_i,
  input  logic [7:0]                  temperature_c_i,
  input  logic                        turbo_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [acfe_pkg::DurW-1:0]   mark_us_o,
  output logic [acfe_pkg::DurW-1:0]   space_us_o,
  output logic                        last_o,
  output logic                        status_o
);
  import acfe_pkg::*;

  logic            ac_protocol_q;
  logic            s1_valid_q;
  logic            req_q;
  logic            power_q;
  logic [2:0]      mode_q;
  logic [1:0]      fan_q;
  logic [7:0]      temp_q;
  logic            turbo_q;

  frame_t          frame_q;
  frame_t          frame_d;
  logic            proto_q;
  logic            active_q;
  logic [IdxW-1:0] idx_q;

  logic            out_valid_q;
  pair_t           out_pair_q;
  logic            status_q;

  logic            adv;
  logic            is_start;
  logic            gen_proto;
  logic [IdxW-1:0] gen_idx;
  pair_t           pair;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign is_start   = (req_q == REQ_START);
  assign gen_proto  = is_start ? ac_protocol_q : proto_q;
  assign gen_idx    = is_start ? '0 : idx_q;

  acfe_frame_build u_build (
    .proto_i         (ac_protocol_q),
    .power_on_i      (power_q),
    .mode_i          (mode_q),
    .fan_speed_i     (fan_q),
    .temperature_c_i (temp_q),
    .turbo_i         (turbo_q),
    .frame_o         (frame_d)
  );

  acfe_pair_gen u_pair (
    .proto_i (gen_proto),
    .idx_i   (gen_idx),
    .frame_i (frame_q),
    .pair_o  (pair)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ac_protocol_q <= PROTO_SIX;
    end else if (cfg_we_i) begin
      ac_protocol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q   <= req_type_i;
      power_q <= power_on_i;
      mode_q  <= mode_i;
      fan_q   <= fan_speed_i;
      temp_q  <= temperature_c_i;
      turbo_q <= turbo_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && is_start) begin
      frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q  <= PROTO_SIX;
      active_q <= 1'b0;
      idx_q    <= '0;
    end else if (adv) begin
      if (is_start) begin
        proto_q  <= ac_protocol_q;
        active_q <= 1'b1;
        idx_q    <= 7'd1;
      end else if (active_q) begin
        if (pair.last) begin
          active_q <= 1'b0;
          idx_q    <= '0;
        end else begin
          idx_q <= idx_q + 7'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (is_start || active_q) begin
        out_pair_q <= pair;
        status_q   <= 1'b0;
      end else begin
        out_pair_q <= '0;
        status_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign mark_us_o   = out_pair_q.mark;
  assign space_us_o  = out_pair_q.space;
  assign last_o      = out_pair_q.last;
  assign status_o    = status_q;

endmodule

@@ sv/acfe_checker.sv @@
// Port-level checks for the IR frame encoder top level, attached by bind.
// Depends on ac_ir_remote_frame_encoder_core.
module acfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [12:0] mark_us_o,
  input logic [12:0] space_us_o,
  input logic        last_o,
  input logic        status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mark_us_o)
      && $stable(space_us_o) && $stable(last_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> mark_us_o == '0 && space_us_o == '0 && !last_o)
    else $error("no-frame result carries a pair");

  a_last_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> space_us_o == '0 && mark_us_o != '0 && !status_o)
    else $error("final pair malformed");

endmodule

bind ac_ir_remote_frame_encoder_core acfe_checker u_acfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .mark_us_o   (mark_us_o),
  .space_us_o  (space_us_o),
  .last_o      (last_o),
  .status_o    (status_o)
);
